@@ rtl/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque: operation codes,
// status codes, field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef logic signed [DATA_W-1:0] t_data;

    // Operation codes carried by one input transfer
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

endpackage

@@ rtl/circular_deque_top.sv @@
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue of signed 32-bit values held in a DEPTH-entry ring.
//
// Input channel (i_in_valid / o_in_stall): one transfer carries an op
// (push front, push back, pop front, pop back, dump) and a push value.
// Output channel (o_out_valid / i_out_stall): each result carries status,
// element and last. Push and pop give one result, with status full when a
// push finds the ring full and empty when a pop finds it empty. A dump
// streams all stored elements front to back, last set on the final one;
// an empty dump gives one empty result. Unknown ops give no result.
//
// A push or pop result is registered and appears in the cycle after its
// input transfer; push and pop are taken back to back unless stalled. A dump
// enters S_DUMP and issues store reads; each registered read word moves to the
// output register, one element per cycle unless the receiver stalls, paced
// by the single store read port. No new input is taken while a dump streams.
// Reset (synchronous, active low) empties the ring; store contents are not
// cleared. When the receiver stalls, the output register holds its result
// and o_in_stall rises until it is taken.
// ----------------------------------------------------------------------------
module circular_deque_top
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_op,
    input  t_data               i_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output t_data               o_element,
    output logic                o_last
);

    localparam int AW = $clog2(DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_data         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_data         mem_rdata;

    // pointer logic and dump sequencer
    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_element   (o_element),
        .o_last      (o_last),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // element store
    cdq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

@@ rtl/cdq_store.sv @@
// ----------------------------------------------------------------------------
// cdq_store
// Element store of the deque: one write port, one read port, registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module cdq_store
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_data         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_data         o_rdata
);

    t_data r_mem [DEPTH];
    t_data r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdq_ctrl
// Ring pointer logic and dump sequencer. Push and pop update the count and,
// for front ops, the front index; a dump walks the store one read per cycle
// unless the output stalls, and drains read data into the output register.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_op,
    input  t_data               i_value,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output t_data               o_element,
    output logic                o_last,
    // store ports
    output logic                o_mem_we,
    output logic [AW-1:0]       o_mem_waddr,
    output t_data               o_mem_wdata,
    output logic                o_mem_re,
    output logic [AW-1:0]       o_mem_raddr,
    input  t_data               i_mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] RING_LEN = SW'(DEPTH);

    // ring position base + off, with base + off below twice the depth
    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= RING_LEN) begin
            s = s - RING_LEN;
        end
        return s[AW-1:0];
    endfunction

    t_state          r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_issue, n_issue;
    logic [CW-1:0]   r_cons, n_cons;
    logic            r_rd_pend, n_rd_pend;
    logic            r_out_valid, n_out_valid;
    t_status         r_status, n_status;
    t_data           r_element, n_element;
    logic            r_last, n_last;

    logic            out_free;
    logic            accept;
    logic            consume;
    logic            issue;
    logic            dump_last;
    logic [AW-1:0]   front_dec;
    logic [AW-1:0]   front_inc;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign accept    = i_in_valid && (r_state == S_IDLE) && out_free;
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - AW'(1);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);

    // dump drain: consume read data into the output register, keep one read
    // in flight; a push written in an earlier cycle is always visible
    assign consume   = (r_state == S_DUMP) && r_rd_pend && out_free;
    assign issue     = (r_state == S_DUMP) && (r_issue != r_count)
                       && (!r_rd_pend || consume);
    assign dump_last = (r_cons == r_count - CW'(1));

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_issue     = r_issue;
        n_cons      = r_cons;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_element   = r_element;
        n_last      = r_last;
        o_mem_we    = 1'b0;
        o_mem_waddr = ring_pos(r_front, r_count);
        o_mem_wdata = i_value;
        o_mem_re    = issue;
        o_mem_raddr = ring_pos(r_front, r_issue);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_op))
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            n_element   = '0;
                            n_last      = 1'b1;
                            if (r_count == FULL_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_OK;
                                n_count  = r_count + CW'(1);
                                o_mem_we = 1'b1;
                                if (t_op'(i_op) == OP_PUSH_FRONT) begin
                                    n_front     = front_dec;
                                    o_mem_waddr = front_dec;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            n_out_valid = 1'b1;
                            n_element   = '0;
                            n_last      = 1'b1;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_status = ST_OK;
                                n_count  = r_count - CW'(1);
                                if (t_op'(i_op) == OP_POP_FRONT) begin
                                    n_front = front_inc;
                                end
                            end
                        end
                        OP_DUMP: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_EMPTY;
                                n_element   = '0;
                                n_last      = 1'b1;
                            end else begin
                                n_state   = S_DUMP;
                                n_issue   = '0;
                                n_cons    = '0;
                                n_rd_pend = 1'b0;
                            end
                        end
                        default: begin
                            // unknown op: dropped without a result
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (consume) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_element   = i_mem_rdata;
                    n_last      = dump_last;
                    n_cons      = r_cons + CW'(1);
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end
                end
                if (issue) begin
                    n_issue   = r_issue + CW'(1);
                    n_rd_pend = 1'b1;
                end else if (consume) begin
                    n_rd_pend = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_issue     <= '0;
            r_cons      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_cons      <= n_cons;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_element <= n_element;
        r_last    <= n_last;
    end

    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_element   = r_element;
    assign o_last      = r_last;

endmodule

@@ rtl/cdq_checker.sv @@
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks for the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker
    import cdq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic [STATUS_W-1:0] o_status,
    input  t_data               o_element,
    input  logic                o_last
);

    // a stalled result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_element) && $stable(o_last))
        else $error("stalled result changed");

    // non-ok status always ends its operation and carries no element
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_last && (o_element == '0))
        else $error("error status not a single last result");

    // no new input is taken while a dump is still streaming
    a_dump_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_in_stall)
        else $error("input taken during dump");

    // after a non-last element is taken, the next one follows at once
    a_dump_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid)
        else $error("dump stream gap");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_element   (o_element),
    .o_last      (o_last)
);
